/* rtl/lcfd_pkg.sv */
package lcfd_pkg;

    // Header pattern "DSDS" and its byte sum
    localparam logic [7:0]  HDR_D   = 8'h44;
    localparam logic [7:0]  HDR_S   = 8'h53;
    localparam logic [23:0] HDR_TRIPLE = {HDR_D, HDR_S, HDR_D};
    localparam logic [7:0]  HDR_SUM = 8'(HDR_D + HDR_S + HDR_D + HDR_S);

    // Smallest legal frame, first body position, and config reset value
    localparam int          MIN_FRAME_LEN = 8;
    localparam int          FIRST_POS     = 4;
    localparam int          CFG_W         = 10;
    localparam logic [9:0]  CFG_RESET     = 10'd512;

    // Output field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_TYPE  = 5'b00010,
        PH_LENHI = 5'b00100,
        PH_LENLO = 5'b01000,
        PH_BODY  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SUM   = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    // One result from the parser toward the output register
    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   frame_byte;
        logic [POS_W-1:0]    byte_pos;
        logic                last;
        status_t             status;
    } result_t;

endpackage

/* rtl/length_checksum_frame_deframer.sv */
// Frame deframer: hunts the byte stream for the header "DSDS", then passes
// every frame byte from position 4 on (type, length, body, checksum) with its
// position; header and hunted bytes give no output. The last output of a
// frame carries tlast and a status in tuser (ok, bad checksum, bad length,
// truncated by an input tlast). One byte is taken every clock; each result
// appears from the output register in the cycle after its input transfer, and
// input is stalled only while that register holds a result not yet taken.
module length_checksum_frame_deframer import lcfd_pkg::*; #(
    parameter int MAX_FRAME = 512
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,       // max_frame_len

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    input  logic              s_axis_tlast,   // chunk_end

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [7:0] frame_byte, [16:8] byte_pos
    output logic              m_axis_tlast,   // frame_last
    output logic [1:0]        m_axis_tuser    // [1:0] frame_status
);

    logic [CFG_W-1:0]  max_len_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;
    status_t           out_status_reg;

    logic              step;
    result_t           res;

    // Length limit register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    // Accept input whenever the output register is free or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    lcfd_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (s_axis_tdata),
        .chunk_end (s_axis_tlast),
        .max_len   (max_len_reg),
        .res       (res)
    );

    // Output register: load on a transfer, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= res.valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_byte_reg   <= res.frame_byte;
            out_pos_reg    <= res.byte_pos;
            out_last_reg   <= res.last;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_pos_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

/* rtl/lcfd_parser.sv */
module lcfd_parser import lcfd_pkg::*; #(
    parameter int MAX_FRAME = 512
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              chunk_end,
    input  logic [CFG_W-1:0]  max_len,
    output result_t           res
);

    localparam int LEN_W = $clog2(MAX_FRAME + 1);

    logic [23:0]      recent_reg, recent_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [LEN_W-1:0] pkt_len_reg, pkt_len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;

    logic [15:0]      hdr_len;
    logic [15:0]      limit;
    logic             body_end;

    // Limit in force is the smaller of the register and the build maximum
    always_comb begin
        if (16'(max_len) > 16'(MAX_FRAME)) begin
            limit = 16'(MAX_FRAME);
        end else begin
            limit = 16'(max_len);
        end
    end

    assign hdr_len  = {len_hi_reg, rx_byte};
    assign body_end = ({1'b0, pos_reg} + (LEN_W+1)'(1)) >= {1'b0, pkt_len_reg};

    // Next state and result for the byte at the input
    always_comb begin
        recent_next  = recent_reg;
        phase_next   = phase_reg;
        len_hi_next  = len_hi_reg;
        pkt_len_next = pkt_len_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;

        res            = '0;
        res.frame_byte = rx_byte;
        res.byte_pos   = POS_W'(pos_reg);
        res.status     = ST_OK;

        case (phase_reg)
            PH_TYPE: begin
                res.valid  = 1'b1;
                sum_next   = sum_reg + rx_byte;
                pos_next   = pos_reg + LEN_W'(1);
                phase_next = PH_LENHI;
            end
            PH_LENHI: begin
                res.valid   = 1'b1;
                sum_next    = sum_reg + rx_byte;
                len_hi_next = rx_byte;
                pos_next    = pos_reg + LEN_W'(1);
                phase_next  = PH_LENLO;
            end
            PH_LENLO: begin
                res.valid = 1'b1;
                sum_next  = sum_reg + rx_byte;
                if (hdr_len < 16'(MIN_FRAME_LEN) || hdr_len > limit) begin
                    res.last   = 1'b1;
                    res.status = ST_BAD_LEN;
                    phase_next = PH_HUNT;
                end else begin
                    pkt_len_next = LEN_W'(hdr_len);
                    pos_next     = pos_reg + LEN_W'(1);
                    phase_next   = PH_BODY;
                end
            end
            PH_BODY: begin
                res.valid = 1'b1;
                if (body_end) begin
                    res.last   = 1'b1;
                    res.status = (rx_byte == sum_reg) ? ST_OK : ST_BAD_SUM;
                    phase_next = PH_HUNT;
                end else begin
                    sum_next = sum_reg + rx_byte;
                    pos_next = pos_reg + LEN_W'(1);
                end
            end
            default: begin
                // Hunt: slide the window one byte
                if (recent_reg == HDR_TRIPLE && rx_byte == HDR_S) begin
                    sum_next    = HDR_SUM;
                    pos_next    = LEN_W'(FIRST_POS);
                    recent_next = '0;
                    phase_next  = PH_TYPE;
                end else begin
                    recent_next = {recent_reg[15:0], rx_byte};
                    phase_next  = PH_HUNT;
                end
            end
        endcase

        // Chunk end aborts any open frame and restarts the hunt
        if (chunk_end) begin
            if (res.valid && !res.last) begin
                res.last   = 1'b1;
                res.status = ST_TRUNCATED;
            end
            recent_next = '0;
            phase_next  = PH_HUNT;
        end

        res.valid = res.valid & step;
    end

    // Advance state on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg  <= '0;
            phase_reg   <= PH_HUNT;
            len_hi_reg  <= '0;
            pkt_len_reg <= '0;
            pos_reg     <= '0;
            sum_reg     <= '0;
        end else if (step) begin
            recent_reg  <= recent_next;
            phase_reg   <= phase_next;
            len_hi_reg  <= len_hi_next;
            pkt_len_reg <= pkt_len_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
        end
    end

    // Chunk end always drops back to hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && chunk_end) |=> (phase_reg == PH_HUNT))
        else $error("phase not hunting after chunk end");

    // A result on a chunk-end byte always closes the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && chunk_end && res.valid) |-> res.last)
        else $error("chunk end result not marked last");

    // Status is only nonzero on the last byte of a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.last) |-> (res.status == ST_OK))
        else $error("status set on a non-last byte");

    // Body position never reaches the frame length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (pos_reg < pkt_len_reg))
        else $error("body position past frame length");

endmodule
